FILE: design/afs_pkg.sv
// Shared constants, command codes and types for the LED frame serializer.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package afs_pkg;

    localparam int PORT_COUNT      = 3;
    localparam int PIXELS_PER_PORT = 16;

    localparam int PIXEL_W    = 24;
    localparam int LAST_BIT   = 23;
    localparam int BITPOS_W   = 5;
    localparam int LINE_W     = 3;
    localparam int SLOT_W     = 13;
    localparam int TICK_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int ROW_W      = (PIXELS_PER_PORT > 1) ? $clog2(PIXELS_PER_PORT) : 1;
    localparam int FRAME_BITS = PIXELS_PER_PORT * PIXEL_W;
    localparam int ROW_DATA_W = PORT_COUNT * PIXEL_W;

    // The slot offset is split by 8 with a shift and by 3 with a reciprocal
    // multiply, exact for every 10-bit quotient of the shift.
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int DIV_PROD_W = 2 * (SLOT_W - 3);

    localparam int FUNC_W     = 3;
    localparam int PORT_SEL_W = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_SET_PIXEL = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_PORT  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET_ALL   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_REFRESH   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_SLOTS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIL_SLOTS = 3'd4;

    typedef struct packed {
        logic                bit_active;
        logic [BITPOS_W-1:0] bitpos;
        logic                lt_zero;
        logic                lt_one;
    } slot_info_t;

endpackage

FILE: design/afs_pixel_store.sv
// Pixel color memory: one row per pixel position, one 24-bit lane per chain.
// Lane-masked writes, registered reads, per-entry valid bits for reset to black.
`timescale 1ns / 1ps

module afs_pixel_store (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [afs_pkg::ROW_W-1:0]       wr_row,
    input  logic [afs_pkg::PORT_COUNT-1:0]  wr_lanes,
    input  logic [afs_pkg::PIXEL_W-1:0]     wr_data,
    input  logic                            rd_en,
    input  logic [afs_pkg::ROW_W-1:0]       rd_row,
    output logic [afs_pkg::ROW_DATA_W-1:0]  rd_data
);
    import afs_pkg::*;

    logic [PORT_COUNT-1:0][PIXEL_W-1:0] mem [PIXELS_PER_PORT];
    logic [PORT_COUNT-1:0] valid_reg [PIXELS_PER_PORT];
    logic [PORT_COUNT-1:0][PIXEL_W-1:0] rd_q_reg;
    logic [PORT_COUNT-1:0] rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int p = 0; p < PORT_COUNT; p++) begin
                if (wr_lanes[p]) begin
                    mem[wr_row][p] <= wr_data;
                end
            end
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < PIXELS_PER_PORT; r++) begin
                valid_reg[r] <= '0;
            end
            rd_vld_reg <= '0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_row] <= valid_reg[wr_row] | wr_lanes;
            end
            if (rd_en) begin
                rd_vld_reg <= valid_reg[rd_row];
            end
        end
    end

    always_comb begin
        for (int p = 0; p < PORT_COUNT; p++) begin
            rd_data[p*PIXEL_W +: PIXEL_W] = rd_vld_reg[p] ? rd_q_reg[p] : '0;
        end
    end

endmodule

FILE: design/afs_frame_timer.sv
// Frame timing: configuration registers, tick and slot counters, bit position.
// Depends on afs_pkg; tells the top level which pixel row and bit are on the line.
`timescale 1ns / 1ps

module afs_frame_timer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [afs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [afs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            tick_go,
    input  logic                            refresh_go,
    output logic                            sending,
    output logic                            busy_next,
    output logic [afs_pkg::ROW_W-1:0]       pix_row,
    output afs_pkg::slot_info_t             info
);
    import afs_pkg::*;

    logic [TICK_W-1:0]    slot_period_reg;
    logic [BYTE_W-1:0]    zero_high_reg;
    logic [BYTE_W-1:0]    one_high_reg;
    logic [BYTE_W-1:0]    lead_reg;
    logic [BYTE_W-1:0]    trail_reg;

    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 sending_reg, sending_next;

    logic                 in_pixels;
    logic [SLOT_W:0]      slot_inc;
    logic [SLOT_W:0]      frame_slots;
    logic [SLOT_W-1:0]    rel;
    logic [SLOT_W-4:0]    rel_oct;
    logic [DIV_PROD_W-1:0] div_prod;
    logic [SLOT_W-1:0]    pix;
    logic [SLOT_W-1:0]    pix_base;
    logic [SLOT_W-1:0]    rem;
    logic [BITPOS_W-1:0]  bit_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_period_reg <= 16'd179;
            zero_high_reg   <= 8'd45;
            one_high_reg    <= 8'd115;
            lead_reg        <= 8'd5;
            trail_reg       <= 8'd80;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SLOT_PERIOD: slot_period_reg <= cfg_wdata;
                REG_ZERO_HIGH:   zero_high_reg   <= cfg_wdata[BYTE_W-1:0];
                REG_ONE_HIGH:    one_high_reg    <= cfg_wdata[BYTE_W-1:0];
                REG_LEAD_SLOTS:  lead_reg        <= cfg_wdata[BYTE_W-1:0];
                REG_TRAIL_SLOTS: trail_reg       <= cfg_wdata[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The pixel and bit on the line follow from the slot and the current lead.
    assign rel      = slot_reg - SLOT_W'(lead_reg);
    assign rel_oct  = rel[SLOT_W-1:3];
    assign div_prod = DIV_PROD_W'(rel_oct) * DIV_PROD_W'(DIV3_MUL);
    assign pix      = SLOT_W'(div_prod >> DIV3_SHIFT);
    assign pix_base = (pix << 4) + (pix << 3);
    assign rem      = rel - pix_base;
    assign bit_idx  = BITPOS_W'(LAST_BIT) - rem[BITPOS_W-1:0];

    assign in_pixels = sending_reg && (slot_reg >= SLOT_W'(lead_reg))
                       && (rel < SLOT_W'(FRAME_BITS));
    assign slot_inc = {1'b0, slot_reg} + 1'b1;
    assign frame_slots = (SLOT_W+1)'(lead_reg) + (SLOT_W+1)'(FRAME_BITS)
                         + (SLOT_W+1)'(trail_reg);

    always_comb begin
        tick_next    = tick_reg;
        slot_next    = slot_reg;
        sending_next = sending_reg;
        if (refresh_go) begin
            sending_next = 1'b1;
            tick_next    = '0;
            slot_next    = '0;
        end else if (tick_go && sending_reg) begin
            if (tick_reg >= slot_period_reg) begin
                tick_next = '0;
                slot_next = slot_inc[SLOT_W-1:0];
                if (slot_inc >= frame_slots) begin
                    sending_next = 1'b0;
                    slot_next    = '0;
                end
            end else begin
                tick_next = tick_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg    <= '0;
            slot_reg    <= '0;
            sending_reg <= 1'b0;
        end else begin
            tick_reg    <= tick_next;
            slot_reg    <= slot_next;
            sending_reg <= sending_next;
        end
    end

    assign sending         = sending_reg;
    assign busy_next       = sending_next;
    assign pix_row         = pix[ROW_W-1:0];
    assign info.bit_active = in_pixels;
    assign info.bitpos     = bit_idx;
    assign info.lt_zero    = tick_reg < TICK_W'(zero_high_reg);
    assign info.lt_one     = tick_reg < TICK_W'(one_high_reg);

endmodule

FILE: design/addressable_led_frame_serializer.sv
// Addressable LED frame serializer: top level with command decode, fill sweep
// and result pipeline. Depends on afs_pkg, afs_pixel_store and afs_frame_timer.
//
// Usage: each request on the s_ channel is one command (set pixel, set port,
// set all, refresh, or timer tick), and each produces exactly one result on
// the m_ channel holding the line levels for that tick, the busy flag and the
// accepted flag. A request passes the read stage, then the result register.
// Ticks, single pixel sets and refreshes are taken one per cycle; the pixel
// row for a tick is read from the memory at the request edge and its data is
// registered. An accepted set port or set all command writes one row of the
// memory per cycle, so s_tready stays low until every row is written. After
// reset every pixel reads black, the block is idle and the timing registers
// hold their defaults. When the receiver stalls, the result register and the
// read stage hold their contents and s_tready drops once both are full.
`timescale 1ns / 1ps

module addressable_led_frame_serializer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // port_select[1:0], pixel_index[9:2], red[17:10], green[25:18], blue[33:26]
    input  logic [afs_pkg::S_TDATA_W-1:0]   s_tdata,
    // func[2:0]
    input  logic [afs_pkg::FUNC_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // line_levels[2:0], frame_busy[3], accepted[4]
    output logic [afs_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [afs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [afs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import afs_pkg::*;

    logic [PORT_SEL_W-1:0] port_sel;
    logic [BYTE_W-1:0]     pix_idx;
    logic [PIXEL_W-1:0]    grb;
    logic                  req_accept;
    logic                  port_ok, pix_ok, cmd_ok;

    logic                  sending, busy_next;
    logic [ROW_W-1:0]      pix_row;
    slot_info_t            info;

    logic                  sweep_reg, sweep_next;
    logic [ROW_W-1:0]      sweep_row_reg, sweep_row_next;
    logic [PORT_COUNT-1:0] sweep_lanes_reg, sweep_lanes_next;
    logic [PIXEL_W-1:0]    sweep_data_reg, sweep_data_next;

    logic                  wr_en;
    logic [ROW_W-1:0]      wr_row;
    logic [PORT_COUNT-1:0] wr_lanes;
    logic [PIXEL_W-1:0]    wr_data;
    logic [ROW_DATA_W-1:0] rd_data;

    logic                  s1_valid_reg, s1_tick_reg, s1_busy_reg, s1_acc_reg;
    slot_info_t            s1_info_reg;
    logic                  m_load;
    logic                  m_valid_reg;
    logic [M_TDATA_W-1:0]  m_data_reg;
    logic [LINE_W-1:0]     levels;
    logic [PIXEL_W-1:0]    word;

    assign port_sel = s_tdata[1:0];
    assign pix_idx  = s_tdata[9:2];
    assign grb      = {s_tdata[25:18], s_tdata[17:10], s_tdata[33:26]};

    assign port_ok = {1'b0, port_sel} < (PORT_SEL_W+1)'(PORT_COUNT);
    assign pix_ok  = {1'b0, pix_idx} < (BYTE_W+1)'(PIXELS_PER_PORT);

    always_comb begin
        case (s_tuser)
            FUNC_SET_PIXEL: cmd_ok = port_ok && pix_ok;
            FUNC_SET_PORT:  cmd_ok = port_ok;
            FUNC_SET_ALL:   cmd_ok = 1'b1;
            FUNC_REFRESH:   cmd_ok = !sending;
            FUNC_TICK:      cmd_ok = 1'b1;
            default:        cmd_ok = 1'b0;
        endcase
    end

    assign m_load     = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready   = !sweep_reg && (!s1_valid_reg || m_load);
    assign req_accept = s_tvalid && s_tready;

    afs_frame_timer u_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .tick_go    (req_accept && (s_tuser == FUNC_TICK)),
        .refresh_go (req_accept && (s_tuser == FUNC_REFRESH) && !sending),
        .sending    (sending),
        .busy_next  (busy_next),
        .pix_row    (pix_row),
        .info       (info)
    );

    always_comb begin
        sweep_next       = sweep_reg;
        sweep_row_next   = sweep_row_reg;
        sweep_lanes_next = sweep_lanes_reg;
        sweep_data_next  = sweep_data_reg;
        if (sweep_reg) begin
            if (sweep_row_reg == ROW_W'(PIXELS_PER_PORT - 1)) begin
                sweep_next = 1'b0;
            end
            sweep_row_next = sweep_row_reg + 1'b1;
        end else if (req_accept && cmd_ok
                     && ((s_tuser == FUNC_SET_PORT) || (s_tuser == FUNC_SET_ALL))) begin
            sweep_next       = 1'b1;
            sweep_row_next   = '0;
            sweep_data_next  = grb;
            sweep_lanes_next = (s_tuser == FUNC_SET_ALL) ? {PORT_COUNT{1'b1}}
                               : PORT_COUNT'(1) << port_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= 1'b0;
        end else begin
            sweep_reg <= sweep_next;
        end
        sweep_row_reg   <= sweep_row_next;
        sweep_lanes_reg <= sweep_lanes_next;
        sweep_data_reg  <= sweep_data_next;
    end

    always_comb begin
        if (sweep_reg) begin
            wr_en    = 1'b1;
            wr_row   = sweep_row_reg;
            wr_lanes = sweep_lanes_reg;
            wr_data  = sweep_data_reg;
        end else begin
            wr_en    = req_accept && cmd_ok && (s_tuser == FUNC_SET_PIXEL);
            wr_row   = pix_idx[ROW_W-1:0];
            wr_lanes = PORT_COUNT'(1) << port_sel;
            wr_data  = grb;
        end
    end

    afs_pixel_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_row   (wr_row),
        .wr_lanes (wr_lanes),
        .wr_data  (wr_data),
        .rd_en    (req_accept && (s_tuser == FUNC_TICK)),
        .rd_row   (pix_row),
        .rd_data  (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (req_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (m_load) begin
            s1_valid_reg <= 1'b0;
        end
        if (req_accept) begin
            s1_tick_reg <= s_tuser == FUNC_TICK;
            s1_busy_reg <= busy_next;
            s1_acc_reg  <= cmd_ok;
            s1_info_reg <= info;
        end
    end

    always_comb begin
        levels = '0;
        word   = '0;
        for (int p = 0; p < LINE_W; p++) begin
            if (p < PORT_COUNT) begin
                word = rd_data[p*PIXEL_W +: PIXEL_W];
                levels[p] = s1_tick_reg && s1_info_reg.bit_active
                            && (word[s1_info_reg.bitpos] ? s1_info_reg.lt_one
                                                         : s1_info_reg.lt_zero);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (m_load) begin
            m_data_reg <= M_TDATA_W'({s1_acc_reg, s1_busy_reg, levels});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: design/afs_checker.sv
// Port-level checks for the LED frame serializer, bound to the top level.
// Depends on afs_pkg and the top level's port list.
`timescale 1ns / 1ps

module afs_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [afs_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [afs_pkg::FUNC_W-1:0]      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [afs_pkg::M_TDATA_W-1:0]   m_tdata
);
    import afs_pkg::*;

    // No result may come out of reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A high line only comes from a tick, and ticks are always accepted.
    a_levels_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != 3'd0) |-> m_tdata[4])
        else $error("line high on a result not accepted");

    // Set all and in-range set port requests block input for the sweep.
    a_sweep_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && ((s_tuser == FUNC_SET_ALL)
        || ((s_tuser == FUNC_SET_PORT) && (s_tdata[1:0] != 2'd3))) |=> !s_tready)
        else $error("request taken during fill sweep");

endmodule

bind addressable_led_frame_serializer afs_checker u_afs_checker (.*);

FILE: test/testbench.sv
// Self-checking bench for addressable_led_frame_serializer: directed and random pixel
// commands, refreshes and timer ticks, checked against a behavioral predictor.
// Depends on afs_pkg and the serializer RTL.
`timescale 1ns / 1ps

module testbench;
    import afs_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_RESERVED_LO = 3'd5;
    localparam int STORE_DEPTH   = PORT_COUNT * PIXELS_PER_PORT;
    localparam int STORE_IDX_W   = $clog2(STORE_DEPTH);
    localparam int IDLE_PERCENT  = 14;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [PORT_SEL_W-1:0] port;
        logic [BYTE_W-1:0]     pixel;
        logic [BYTE_W-1:0]     red;
        logic [BYTE_W-1:0]     green;
        logic [BYTE_W-1:0]     blue;
    } led_request_t;

    typedef struct packed {
        logic [LINE_W-1:0] levels;
        logic              busy;
        logic              accepted;
    } led_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [FUNC_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predicted block state and timing registers.
    logic [PIXEL_W-1:0] grb_store [STORE_DEPTH];
    bit                 frame_active;
    int unsigned        slot_idx, tick_idx;
    int unsigned        period_cfg, zero_high_cfg, one_high_cfg, lead_cfg, trail_cfg;

    led_request_t pending_requests [$];
    led_result_t  expected_results [$];
    led_request_t current_request;

    int unsigned items_queued      = 0;
    int unsigned requests_accepted = 0;
    int unsigned results_checked   = 0;
    int unsigned mismatches        = 0;
    int unsigned quiet_cycles      = 0;
    int unsigned color_writes      = 0;
    int unsigned frames_started    = 0;
    int unsigned frames_finished   = 0;
    bit          idle_free;

    addressable_led_frame_serializer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    assign idle_free = requests_accepted >= 300 && requests_accepted < 700;

    function automatic led_result_t serialize_step(led_request_t rq);
        led_result_t        res;
        logic [PIXEL_W-1:0] grb;
        int unsigned        rel, pix, bitpos, high;
        int                 i;
        res = '0;
        grb = {rq.green, rq.red, rq.blue};
        case (rq.func)
            FUNC_SET_PIXEL: begin
                if (rq.port < PORT_COUNT && rq.pixel < PIXELS_PER_PORT) begin
                    grb_store[STORE_IDX_W'(rq.port * PIXELS_PER_PORT + rq.pixel)] = grb;
                    res.accepted = 1'b1;
                    color_writes++;
                end
            end
            FUNC_SET_PORT: begin
                if (rq.port < PORT_COUNT) begin
                    for (i = 0; i < PIXELS_PER_PORT; i++)
                        grb_store[STORE_IDX_W'(rq.port * PIXELS_PER_PORT + i)] = grb;
                    res.accepted = 1'b1;
                    color_writes++;
                end
            end
            FUNC_SET_ALL: begin
                for (i = 0; i < STORE_DEPTH; i++)
                    grb_store[STORE_IDX_W'(i)] = grb;
                res.accepted = 1'b1;
                color_writes++;
            end
            FUNC_REFRESH: begin
                if (!frame_active) begin
                    frame_active = 1'b1;
                    slot_idx = 0;
                    tick_idx = 0;
                    res.accepted = 1'b1;
                    frames_started++;
                end
            end
            FUNC_TICK: begin
                res.accepted = 1'b1;
                if (frame_active) begin
                    if (slot_idx >= lead_cfg && slot_idx - lead_cfg < FRAME_BITS) begin
                        rel = slot_idx - lead_cfg;
                        pix = rel / PIXEL_W;
                        bitpos = LAST_BIT - rel % PIXEL_W;
                        for (i = 0; i < PORT_COUNT; i++) begin
                            high = grb_store[STORE_IDX_W'(i * PIXELS_PER_PORT + pix)]
                                            [BITPOS_W'(bitpos)] ?
                                   one_high_cfg : zero_high_cfg;
                            if (tick_idx < high)
                                res.levels[i] = 1'b1;
                        end
                    end
                    if (tick_idx >= period_cfg) begin
                        tick_idx = 0;
                        slot_idx = (slot_idx + 1) % (1 << SLOT_W);
                        if (slot_idx >= lead_cfg + FRAME_BITS + trail_cfg) begin
                            frame_active = 1'b0;
                            slot_idx = 0;
                            frames_finished++;
                        end
                    end else begin
                        tick_idx = (tick_idx + 1) % (1 << TICK_W);
                    end
                end
            end
            default: begin
            end
        endcase
        res.busy = frame_active;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: mismatch on %s after %0d results: got %0h, expected %0h",
                     $realtime, what, results_checked, got, want);
    endtask

    task automatic queue_request(input logic [FUNC_W-1:0] func, input int unsigned port,
                                 input int unsigned pixel, input int unsigned red,
                                 input int unsigned green, input int unsigned blue);
        led_request_t rq;
        rq.func  = func;
        rq.port  = PORT_SEL_W'(port);
        rq.pixel = BYTE_W'(pixel);
        rq.red   = BYTE_W'(red);
        rq.green = BYTE_W'(green);
        rq.blue  = BYTE_W'(blue);
        pending_requests.push_back(rq);
        items_queued++;
    endtask

    task automatic queue_tick();
        queue_request(FUNC_TICK, $urandom_range(3), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255));
    endtask

    task automatic queue_random_command(input bit allow_refresh);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
            queue_request(FUNC_SET_PIXEL, $urandom_range(3),
                          ($urandom_range(4) == 0) ? $urandom_range(255)
                                                   : $urandom_range(PIXELS_PER_PORT - 1),
                          $urandom_range(255), $urandom_range(255), $urandom_range(255));
        else if (pick < 58)
            queue_request(FUNC_SET_PORT, $urandom_range(3), $urandom_range(255),
                          $urandom_range(255), $urandom_range(255), $urandom_range(255));
        else if (pick < 64)
            queue_request(FUNC_SET_ALL, $urandom_range(3), $urandom_range(255),
                          $urandom_range(255), $urandom_range(255), $urandom_range(255));
        else if (pick < 78 && allow_refresh)
            queue_request(FUNC_REFRESH, $urandom_range(3), $urandom_range(255),
                          $urandom_range(255), $urandom_range(255), $urandom_range(255));
        else
            queue_request(FUNC_RESERVED_LO + FUNC_W'($urandom_range(2)), $urandom_range(3),
                          $urandom_range(255), $urandom_range(255), $urandom_range(255),
                          $urandom_range(255));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
    endtask

    task automatic program_timing(input int unsigned period, input int unsigned zero_high,
                                  input int unsigned one_high, input int unsigned lead,
                                  input int unsigned trail);
        write_reg(REG_SLOT_PERIOD, period);
        write_reg(REG_ZERO_HIGH, zero_high);
        write_reg(REG_ONE_HIGH, one_high);
        write_reg(REG_LEAD_SLOTS, lead);
        write_reg(REG_TRAIL_SLOTS, trail);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        period_cfg    = period;
        zero_high_cfg = zero_high;
        one_high_cfg  = one_high;
        lead_cfg      = lead;
        trail_cfg     = trail;
    endtask

    task automatic wait_drained();
        wait (results_checked == items_queued);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : drive_requests
        led_request_t rq;
        bit           hold;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(serialize_step(current_request));
                requests_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                hold = !idle_free && $urandom_range(99) < IDLE_PERCENT;
                if (pending_requests.size() > 0 && !hold) begin
                    rq = pending_requests.pop_front();
                    current_request = rq;
                    s_tdata  <= S_TDATA_W'({rq.blue, rq.green, rq.red, rq.pixel, rq.port});
                    s_tuser  <= rq.func;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_results
        led_result_t want;
        if (aresetn) begin
            m_tready <= idle_free || $urandom_range(99) >= IDLE_PERCENT;
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request outstanding", 32'(m_tdata), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[LINE_W-1:0] !== want.levels)
                        report_mismatch("line_levels", 32'(m_tdata[LINE_W-1:0]),
                                        32'(want.levels));
                    if (m_tdata[LINE_W] !== want.busy)
                        report_mismatch("frame_busy", 32'(m_tdata[LINE_W]), 32'(want.busy));
                    if (m_tdata[LINE_W+1] !== want.accepted)
                        report_mismatch("accepted", 32'(m_tdata[LINE_W+1]),
                                        32'(want.accepted));
                end
                results_checked++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned frame_ticks, ticks_queued, k;
        for (k = 0; k < STORE_DEPTH; k++)
            grb_store[STORE_IDX_W'(k)] = '0;
        frame_active  = 1'b0;
        slot_idx      = 0;
        tick_idx      = 0;
        period_cfg    = 179;
        zero_high_cfg = 45;
        one_high_cfg  = 115;
        lead_cfg      = 5;
        trail_cfg     = 80;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed commands at the reset timing; no frame is started here.
        queue_request(FUNC_SET_PIXEL, 0, 0, 8'hFF, 8'hFF, 8'hFF);
        queue_request(FUNC_SET_PIXEL, PORT_COUNT - 1, PIXELS_PER_PORT - 1, 8'hFF, 8'h00, 8'h00);
        queue_request(FUNC_SET_PIXEL, PORT_COUNT, 0, 8'h12, 8'h34, 8'h56);
        queue_request(FUNC_SET_PIXEL, 0, PIXELS_PER_PORT, 8'h12, 8'h34, 8'h56);
        queue_request(FUNC_SET_PIXEL, 1, 255, 8'hFF, 8'hFF, 8'hFF);
        queue_request(FUNC_SET_PORT, 1, 0, 8'h5A, 8'hA5, 8'h0F);
        queue_request(FUNC_SET_PORT, 3, 0, 8'hFF, 8'hFF, 8'hFF);
        queue_request(FUNC_SET_ALL, 0, 0, 8'h00, 8'h00, 8'h00);
        queue_request(FUNC_SET_ALL, 3, 255, 8'hFF, 8'hFF, 8'hFF);
        queue_request(FUNC_SET_PORT, 0, 0, 8'h01, 8'h80, 8'h7E);
        queue_tick();
        queue_request(FUNC_RESERVED_LO, 3, 255, 8'hFF, 8'hFF, 8'hFF);
        queue_request(FUNC_RESERVED_LO + FUNC_W'(1), 0, 0, 0, 0, 0);
        queue_request(FUNC_RESERVED_LO + FUNC_W'(2), 2, 128, 8'h80, 8'h80, 8'h80);
        queue_request(FUNC_SET_PIXEL, 2, 0, $urandom_range(255), $urandom_range(255),
                      $urandom_range(255));
        queue_tick();
        wait_drained();

        // Fast slots with a short lead and a short latch gap.
        program_timing(1, 0, 255, 3, 1);
        for (k = 0; k < 12; k++)
            queue_request(FUNC_SET_PIXEL, $urandom_range(PORT_COUNT - 1),
                          $urandom_range(PIXELS_PER_PORT - 1), $urandom_range(255),
                          $urandom_range(255), $urandom_range(255));
        queue_request(FUNC_REFRESH, 0, 0, 0, 0, 0);
        queue_request(FUNC_REFRESH, 3, 255, 8'hFF, 8'hFF, 8'hFF);
        frame_ticks = (lead_cfg + FRAME_BITS + trail_cfg) * (period_cfg + 1);
        ticks_queued = 0;
        while (ticks_queued < frame_ticks + 40) begin
            if ($urandom_range(99) < 12) begin
                queue_random_command(ticks_queued < frame_ticks);
            end else begin
                queue_tick();
                ticks_queued++;
            end
        end
        wait_drained();

        // Longest slot: the tick count runs past every high time in the first bit slot.
        program_timing(65535, 255, 0, 0, 255);
        queue_request(FUNC_SET_PIXEL, 0, 0, 8'hAA, 8'h55, 8'hAA);
        queue_request(FUNC_SET_PIXEL, 1, 0, 8'h00, 8'hFF, 8'h00);
        queue_request(FUNC_SET_PIXEL, 2, 0, 8'hFF, 8'h00, 8'hFF);
        queue_request(FUNC_REFRESH, 1, 7, 0, 0, 0);
        ticks_queued = 0;
        while (ticks_queued < 280) begin
            if ($urandom_range(99) < 12) begin
                queue_random_command(1'b1);
            end else begin
                queue_tick();
                ticks_queued++;
            end
        end
        wait_drained();

        $display("Sent %0d requests and compared %0d results over three timing setups.",
                 requests_accepted, results_checked);
        $display("Color writes taken: %0d; frames started: %0d, run to the end: %0d.",
                 color_writes, frames_started, frames_finished);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
